@@ sv/normalized_sad_template_match_3d_assert.svh @@
// assertion macros for the normalized sad template matcher
// clocked on aclk, disabled while aresetn is low; empty when SYNTHESIS is set
`ifndef NORMALIZED_SAD_TEMPLATE_MATCH_3D_ASSERT_SVH
`define NORMALIZED_SAD_TEMPLATE_MATCH_3D_ASSERT_SVH
`ifndef SYNTHESIS
`define NSAD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nsad assertion failed");
`define NSAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nsad assertion failed");
`else
`define NSAD_ASSERT_IMPL(lbl, ante, cons)
`define NSAD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/nsad_pkg.sv @@
// shared constants, types and port widths of the normalized sad template matcher
// no dependencies; used by nsad_div and normalized_sad_template_match_3d
`default_nettype none

package nsad_pkg;

    // store dimensions and sample width
    localparam int TEMPLATE_DIM = 8;
    localparam int VOLUME_DIM   = 32;
    localparam int SAMPLE_BITS  = 16;

    // fixed field widths
    localparam int POS_W     = 5;
    localparam int RAW_W     = 16;
    localparam int KIND_W    = 2;
    localparam int FRAC_BITS = 16;
    localparam int SCORE_W   = FRAC_BITS + 1;

    // configuration register widths
    localparam int CFG_BG_W = 16;
    localparam int CFG_T_W  = 4;
    localparam int CFG_V_W  = 6;
    localparam logic [CFG_T_W-1:0] CFG_T_RESET = CFG_T_W'(8);
    localparam logic [CFG_V_W-1:0] CFG_V_RESET = CFG_V_W'(32);

    // store sizes and address widths
    localparam int TSIZE = TEMPLATE_DIM * TEMPLATE_DIM * TEMPLATE_DIM;
    localparam int VSIZE = VOLUME_DIM * VOLUME_DIM * VOLUME_DIM;
    localparam int TA_W  = (TSIZE > 1) ? $clog2(TSIZE) : 1;
    localparam int VA_W  = (VSIZE > 1) ? $clog2(VSIZE) : 1;
    localparam int MA_W  = (TA_W > VA_W) ? TA_W : VA_W;
    localparam int TI_W  = (TEMPLATE_DIM > 1) ? $clog2(TEMPLATE_DIM) : 1;
    localparam int TE_W  = $clog2(TEMPLATE_DIM + 1);
    localparam int VE_W  = $clog2(VOLUME_DIM + 1);

    // address steps of the box walk
    localparam logic [TA_W-1:0] T_ROW_STEP  = TA_W'(TEMPLATE_DIM);
    localparam logic [TA_W-1:0] T_SLAB_STEP = TA_W'(TEMPLATE_DIM * TEMPLATE_DIM);
    localparam logic [VA_W-1:0] V_ROW_STEP  = VA_W'(VOLUME_DIM);
    localparam logic [VA_W-1:0] V_SLAB_STEP = VA_W'(VOLUME_DIM * VOLUME_DIM);

    // accumulator widths: diff sum never exceeds the total sum
    localparam int DSUM_W = SAMPLE_BITS + TA_W;
    localparam int TSUM_W = DSUM_W + 1;

    // level difference saturation
    localparam int LD_W = (RAW_W > SAMPLE_BITS) ? RAW_W : SAMPLE_BITS;
    localparam logic [LD_W-1:0]        SAMPLE_MAX_LD = LD_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX    = '1;

    // divider
    localparam int CNT_W = $clog2(SCORE_W + 1);
    localparam logic [SCORE_W-1:0] ONE_FIX = SCORE_W'(1 << FRAC_BITS);

    // stream and register port widths
    localparam int IN_TDATA_W  = ((3 * POS_W + RAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SCORE_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    // register indexes (word address)
    localparam logic [2:0] REG_BG  = 3'd0;
    localparam logic [2:0] REG_TD  = 3'd1;
    localparam logic [2:0] REG_TH  = 3'd2;
    localparam logic [2:0] REG_TW  = 3'd3;
    localparam logic [2:0] REG_VD  = 3'd4;
    localparam logic [2:0] REG_VH  = 3'd5;
    localparam logic [2:0] REG_VW  = 3'd6;

    // input word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TMPL  = 2'd0,
        KIND_VOL   = 2'd1,
        KIND_SCORE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [DSUM_W-1:0] dividend;
        logic [TSUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [SCORE_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/nsad_div.sv @@
// radix-2 restoring divider: floor(dividend * 2^FRAC_BITS / divisor), one bit per cycle
// depends on nsad_pkg; expects dividend <= divisor, so the quotient fits SCORE_W bits
`default_nettype none

module nsad_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  nsad_pkg::div_req_t div_req,
    output nsad_pkg::div_rsp_t div_rsp
);
    import nsad_pkg::*;

    logic [TSUM_W:0]    rem_reg;
    logic [TSUM_W:0]    rem_next;
    logic [TSUM_W:0]    rem_sub;
    logic [TSUM_W-1:0]  dvs_reg;
    logic [SCORE_W-1:0] q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               ge;

    // one compare and subtract per step, then shift the remainder
    always_comb begin
        ge       = rem_reg >= {1'b0, dvs_reg};
        rem_sub  = ge ? (rem_reg - {1'b0, dvs_reg}) : rem_reg;
        rem_next = {rem_sub[TSUM_W-1:0], 1'b0};
    end

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SCORE_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient datapath
    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            rem_reg <= (TSUM_W + 1)'(div_req.dividend);
            dvs_reg <= div_req.divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[SCORE_W-2:0], ge};
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = q_reg;

endmodule

`default_nettype wire

@@ sv/normalized_sad_template_match_3d.sv @@
// load or ignored word: ready again after the check, or after the store write for a load;
// a result is not produced. score word: the walk reads the td*th*tw box voxels (up to 512),
// one template and one volume word per cycle, then a 17-step serial divider makes the ratio
// out-of-range or empty box: no walk and no divide; one score is in work at a time
// reset: synchronous, active low; clears control state and config registers to defaults,
// leaves both stores untouched (no clearing pass)
`default_nettype none
`include "normalized_sad_template_match_3d_assert.svh"

module normalized_sad_template_match_3d (
    input  logic                               aclk,
    input  logic                               aresetn,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nsad_pkg::APB_AW-1:0]        paddr,
    input  logic [nsad_pkg::APB_DW-1:0]        pwdata,
    output logic [nsad_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [nsad_pkg::IN_TDATA_W-1:0]    s_tdata,  // pos_z, pos_y, pos_x, raw_sample
    input  logic [nsad_pkg::KIND_W-1:0]        s_tuser,  // kind
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nsad_pkg::OUT_TDATA_W-1:0]   m_tdata,  // score
    output logic [nsad_pkg::OUT_TUSER_W-1:0]   m_tuser   // zero_sum, range_error
);
    import nsad_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_BASE  = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [CFG_BG_W-1:0] bg_reg;
    logic [CFG_T_W-1:0]  tdep_reg, thgt_reg, twid_reg;
    logic [CFG_V_W-1:0]  vdep_reg, vhgt_reg, vwid_reg;
    logic                cfg_wr;

    // captured word
    kind_t                  kind_reg;
    logic [POS_W-1:0]       pz_reg, py_reg, px_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   in_acc;
    logic [RAW_W-1:0]       raw_in;
    logic [RAW_W-1:0]       abs_raw;
    logic [LD_W-1:0]        abs_ext;
    logic [SAMPLE_BITS-1:0] sample_in;

    // check stage
    logic [TE_W-1:0] td_cap, th_cap, tw_cap;
    logic [VE_W-1:0] vd_cap, vh_cap, vw_cap;
    logic [TE_W-1:0] td_reg, th_reg, tw_reg;
    logic            range_fail, zero_ext, t_pos_ok, v_pos_ok, ok_reg;
    logic [MA_W-1:0] row_t, row_v, row_reg;

    // stores
    logic [SAMPLE_BITS-1:0] tmem [TSIZE];
    logic [SAMPLE_BITS-1:0] vmem [VSIZE];
    logic                   t_we, v_we;
    logic [TA_W-1:0]        t_waddr;
    logic [VA_W-1:0]        v_base;

    // box walk
    logic [TI_W-1:0] i_reg, j_reg, k_reg;
    logic [TA_W-1:0] ta_reg, t_row_reg, t_slab_reg;
    logic [VA_W-1:0] va_reg, v_row_reg, v_slab_reg;
    logic            i_last, j_last, k_last, rd_issue;

    // accumulate pipeline
    logic                   p1_reg, p2_reg;
    logic [SAMPLE_BITS-1:0] t_rd_reg, v_rd_reg, diff_reg;
    logic [SAMPLE_BITS:0]   tot_reg;
    logic [DSUM_W-1:0]      dsum_reg;
    logic [TSUM_W-1:0]      tsum_reg;
    logic                   drained;

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // result and output registers
    logic [SCORE_W-1:0] res_score_reg, out_score_reg;
    logic               res_zero_reg, res_err_reg, out_zero_reg, out_err_reg;
    logic               out_vld_reg, out_free;

    // ---------------------------------------------------------------
    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg   <= '0;
            tdep_reg <= CFG_T_RESET;
            thgt_reg <= CFG_T_RESET;
            twid_reg <= CFG_T_RESET;
            vdep_reg <= CFG_V_RESET;
            vhgt_reg <= CFG_V_RESET;
            vwid_reg <= CFG_V_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[APB_AW-1:2])
                REG_BG:  bg_reg   <= pwdata[CFG_BG_W-1:0];
                REG_TD:  tdep_reg <= pwdata[CFG_T_W-1:0];
                REG_TH:  thgt_reg <= pwdata[CFG_T_W-1:0];
                REG_TW:  twid_reg <= pwdata[CFG_T_W-1:0];
                REG_VD:  vdep_reg <= pwdata[CFG_V_W-1:0];
                REG_VH:  vhgt_reg <= pwdata[CFG_V_W-1:0];
                REG_VW:  vwid_reg <= pwdata[CFG_V_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[APB_AW-1:2])
            REG_BG:  prdata = APB_DW'(bg_reg);
            REG_TD:  prdata = APB_DW'(tdep_reg);
            REG_TH:  prdata = APB_DW'(thgt_reg);
            REG_TW:  prdata = APB_DW'(twid_reg);
            REG_VD:  prdata = APB_DW'(vdep_reg);
            REG_VH:  prdata = APB_DW'(vhgt_reg);
            REG_VW:  prdata = APB_DW'(vwid_reg);
            default: prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // input word capture and level difference
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign raw_in   = s_tdata[3*POS_W+RAW_W-1:3*POS_W];

    always_comb begin
        abs_raw   = (raw_in >= bg_reg) ? (raw_in - bg_reg) : (bg_reg - raw_in);
        abs_ext   = LD_W'(abs_raw);
        sample_in = (abs_ext > SAMPLE_MAX_LD) ? SAMPLE_MAX : SAMPLE_BITS'(abs_ext);
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            kind_reg   <= kind_t'(s_tuser);
            pz_reg     <= s_tdata[POS_W-1:0];
            py_reg     <= s_tdata[2*POS_W-1:POS_W];
            px_reg     <= s_tdata[3*POS_W-1:2*POS_W];
            sample_reg <= sample_in;
        end
    end

    // ---------------------------------------------------------------
    // extent caps, box range check, load bounds and row index
    always_comb begin
        td_cap = (32'(tdep_reg) > TEMPLATE_DIM) ? TE_W'(TEMPLATE_DIM) : TE_W'(tdep_reg);
        th_cap = (32'(thgt_reg) > TEMPLATE_DIM) ? TE_W'(TEMPLATE_DIM) : TE_W'(thgt_reg);
        tw_cap = (32'(twid_reg) > TEMPLATE_DIM) ? TE_W'(TEMPLATE_DIM) : TE_W'(twid_reg);
        vd_cap = (32'(vdep_reg) > VOLUME_DIM) ? VE_W'(VOLUME_DIM) : VE_W'(vdep_reg);
        vh_cap = (32'(vhgt_reg) > VOLUME_DIM) ? VE_W'(VOLUME_DIM) : VE_W'(vhgt_reg);
        vw_cap = (32'(vwid_reg) > VOLUME_DIM) ? VE_W'(VOLUME_DIM) : VE_W'(vwid_reg);

        range_fail = (32'(pz_reg) + 32'(td_cap) > 32'(vd_cap)) ||
                     (32'(py_reg) + 32'(th_cap) > 32'(vh_cap)) ||
                     (32'(px_reg) + 32'(tw_cap) > 32'(vw_cap));
        zero_ext   = (td_cap == '0) || (th_cap == '0) || (tw_cap == '0);

        t_pos_ok = (32'(pz_reg) < TEMPLATE_DIM) && (32'(py_reg) < TEMPLATE_DIM) &&
                   (32'(px_reg) < TEMPLATE_DIM);
        v_pos_ok = (32'(pz_reg) < VOLUME_DIM) && (32'(py_reg) < VOLUME_DIM) &&
                   (32'(px_reg) < VOLUME_DIM);

        row_t = MA_W'(32'(pz_reg) * TEMPLATE_DIM + 32'(py_reg));
        row_v = MA_W'(32'(pz_reg) * VOLUME_DIM + 32'(py_reg));
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_CHECK) begin
            row_reg <= (kind_reg == KIND_TMPL) ? row_t : row_v;
            ok_reg  <= (kind_reg == KIND_TMPL) ? t_pos_ok : v_pos_ok;
            td_reg  <= td_cap;
            th_reg  <= th_cap;
            tw_reg  <= tw_cap;
        end
    end

    // ---------------------------------------------------------------
    // full addresses from the row index
    assign t_waddr = TA_W'(32'(row_reg) * TEMPLATE_DIM + 32'(px_reg));
    assign v_base  = VA_W'(32'(row_reg) * VOLUME_DIM + 32'(px_reg));
    assign t_we    = (state_reg == S_BASE) && (kind_reg == KIND_TMPL) && ok_reg;
    assign v_we    = (state_reg == S_BASE) && (kind_reg == KIND_VOL) && ok_reg;
    assign rd_issue = (state_reg == S_WALK);

    // template store
    always_ff @(posedge aclk) begin
        if (t_we) begin
            tmem[t_waddr] <= sample_reg;
        end
        if (rd_issue) begin
            t_rd_reg <= tmem[ta_reg];
        end
    end

    // volume store
    always_ff @(posedge aclk) begin
        if (v_we) begin
            vmem[v_base] <= sample_reg;
        end
        if (rd_issue) begin
            v_rd_reg <= vmem[va_reg];
        end
    end

    // ---------------------------------------------------------------
    // box walk: x fastest, then y, then z
    assign i_last = (TE_W'(i_reg) == tw_reg - TE_W'(1));
    assign j_last = (TE_W'(j_reg) == th_reg - TE_W'(1));
    assign k_last = (TE_W'(k_reg) == td_reg - TE_W'(1));

    always_ff @(posedge aclk) begin
        if (state_reg == S_BASE) begin
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            ta_reg     <= '0;
            t_row_reg  <= '0;
            t_slab_reg <= '0;
            va_reg     <= v_base;
            v_row_reg  <= v_base;
            v_slab_reg <= v_base;
        end else if (state_reg == S_WALK) begin
            if (!i_last) begin
                i_reg  <= i_reg + TI_W'(1);
                ta_reg <= ta_reg + TA_W'(1);
                va_reg <= va_reg + VA_W'(1);
            end else if (!j_last) begin
                i_reg     <= '0;
                j_reg     <= j_reg + TI_W'(1);
                t_row_reg <= t_row_reg + T_ROW_STEP;
                ta_reg    <= t_row_reg + T_ROW_STEP;
                v_row_reg <= v_row_reg + V_ROW_STEP;
                va_reg    <= v_row_reg + V_ROW_STEP;
            end else if (!k_last) begin
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= k_reg + TI_W'(1);
                t_slab_reg <= t_slab_reg + T_SLAB_STEP;
                t_row_reg  <= t_slab_reg + T_SLAB_STEP;
                ta_reg     <= t_slab_reg + T_SLAB_STEP;
                v_slab_reg <= v_slab_reg + V_SLAB_STEP;
                v_row_reg  <= v_slab_reg + V_SLAB_STEP;
                va_reg     <= v_slab_reg + V_SLAB_STEP;
            end
        end
    end

    // ---------------------------------------------------------------
    // read-data valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
        end else begin
            p1_reg <= rd_issue;
            p2_reg <= p1_reg;
        end
    end

    // absolute difference and pair sum, then accumulate
    always_ff @(posedge aclk) begin
        if (p1_reg) begin
            diff_reg <= (v_rd_reg >= t_rd_reg) ? (v_rd_reg - t_rd_reg) : (t_rd_reg - v_rd_reg);
            tot_reg  <= (SAMPLE_BITS + 1)'(v_rd_reg) + (SAMPLE_BITS + 1)'(t_rd_reg);
        end
        if (state_reg == S_BASE) begin
            dsum_reg <= '0;
            tsum_reg <= '0;
        end else if (p2_reg) begin
            dsum_reg <= dsum_reg + DSUM_W'(diff_reg);
            tsum_reg <= tsum_reg + TSUM_W'(tot_reg);
        end
    end

    assign drained = !p1_reg && !p2_reg;

    // ---------------------------------------------------------------
    // serial divider
    always_comb begin
        div_req.start    = (state_reg == S_DRAIN) && drained && (tsum_reg != '0);
        div_req.dividend = dsum_reg;
        div_req.divisor  = tsum_reg;
    end

    nsad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // ---------------------------------------------------------------
    // sequencer
    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) state_next = S_CHECK;
            end
            S_CHECK: begin
                unique case (kind_reg)
                    KIND_TMPL, KIND_VOL: state_next = S_BASE;
                    KIND_SCORE:          state_next = (range_fail || zero_ext) ? S_OUT : S_BASE;
                    KIND_NONE:           state_next = S_IDLE;
                    default:             state_next = S_IDLE;
                endcase
            end
            S_BASE: begin
                state_next = (kind_reg == KIND_SCORE) ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                if (i_last && j_last && k_last) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (drained) state_next = (tsum_reg == '0) ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // pending result
    always_ff @(posedge aclk) begin
        if (state_reg == S_CHECK) begin
            res_score_reg <= '0;
            res_zero_reg  <= !range_fail;
            res_err_reg   <= range_fail;
        end else if ((state_reg == S_DRAIN) && drained) begin
            res_score_reg <= '0;
            res_zero_reg  <= 1'b1;
            res_err_reg   <= 1'b0;
        end else if ((state_reg == S_DIV) && div_rsp.done) begin
            res_score_reg <= div_rsp.quotient;
            res_zero_reg  <= 1'b0;
            res_err_reg   <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if ((state_reg == S_OUT) && out_free) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && out_free) begin
            out_score_reg <= res_score_reg;
            out_zero_reg  <= res_zero_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TDATA_W'(out_score_reg);
    assign m_tuser  = {out_err_reg, out_zero_reg};

    // ---------------------------------------------------------------
    // checks
    `NSAD_ASSERT_IMPL(a_err_clears_score, m_tvalid && m_tuser[1], out_score_reg == '0 && !out_zero_reg)
    `NSAD_ASSERT_IMPL(a_zero_clears_score, m_tvalid && out_zero_reg, out_score_reg == '0)
    `NSAD_ASSERT_IMPL(a_score_at_most_one, m_tvalid, out_score_reg <= ONE_FIX)
    `NSAD_ASSERT_IMPL(a_walk_in_box, state_reg == S_WALK, TE_W'(i_reg) < tw_reg && TE_W'(j_reg) < th_reg && TE_W'(k_reg) < td_reg)
    `NSAD_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_reg == S_DIV)
    `NSAD_ASSERT_NEXT(a_start_enters_div, div_req.start, state_reg == S_DIV)

endmodule

`default_nettype wire
